FILE: design/tls_record_deframer_defines.svh
// Assertion macros shared by the record deframer RTL.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef TLS_RECORD_DEFRAMER_DEFINES_SVH
`define TLS_RECORD_DEFRAMER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TLSD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TLSD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/tlsd_pkg.sv
// Package for the record deframer: constants, codes and shared types.
// Used by every RTL module of the block; depends on nothing.
package tlsd_pkg;

  localparam int unsigned HDR_DEPTH = 13;
  localparam int unsigned HDR_CNT_W = $clog2(HDR_DEPTH + 1);

  localparam logic [HDR_CNT_W-1:0] TLS_HEAD_CNT  = HDR_CNT_W'(5);
  localparam logic [HDR_CNT_W-1:0] DTLS_HEAD_CNT = HDR_CNT_W'(HDR_DEPTH);

  localparam logic [15:0] MAX_RECORD_LEN = 16'(16384 + 2048);
  localparam logic [7:0]  TYPE_LOW       = 8'd20;
  localparam logic [7:0]  TYPE_HIGH      = 8'd23;
  localparam logic [6:0]  MAC_LEN_RESET  = 7'd20;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_SKIP    = 2'd2,
    PH_HALT    = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_TYPE = 3'd1,
    ST_OVERFLOW = 3'd2,
    ST_SHORT    = 3'd3,
    ST_STALE    = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CFG_DTLS_MODE  = 2'd0,
    CFG_MAC_LENGTH = 2'd1,
    CFG_READ_EPOCH = 2'd2
  } cfg_idx_e;

  typedef logic [HDR_DEPTH-1:0][7:0] hdr_bytes_t;

  typedef struct packed {
    status_e     status;
    logic        fatal;
    logic        skip;
    logic [63:0] seq;
    logic [7:0]  content_type;
    logic [15:0] version;
    logic [15:0] length;
  } hdr_info_t;

  typedef struct packed {
    logic        is_payload;
    status_e     status;
    logic [7:0]  content_type;
    logic [15:0] version;
    logic [15:0] record_length;
    logic [63:0] record_sequence;
    logic [7:0]  payload_byte;
    logic        last;
  } result_t;

endpackage

FILE: design/tls_record_deframer.sv
// Record deframer for TLS and DTLS byte streams: input register, record state
// machine and header checks, result register. Depends on tlsd_pkg,
// tlsd_hdr_check, tlsd_out_reg and tls_record_deframer_defines.svh.
//
// Usage: stream bytes enter on in_valid_i/in_stall_o, one word per byte.
// Each byte is held in an input register, decoded in the next cycle and, if
// it causes a result, written into the result register, whose word is then
// offered on out_valid_o until the receiver takes it. A header word
// follows the last header byte; payload words follow their bytes one for one.
// One byte is taken every cycle as long as the receiver takes results; the
// figure is set by the single decode stage between the two registers.
// When the receiver stalls with a result waiting, the input register fills
// and in_stall_o rises in the same cycle as a byte that would need the result
// register; bytes that yield no result (header bytes, skipped payload) still
// drain. Configuration writes are always taken (cfg_ready_o is tied high) and
// are meant for idle periods. Reset clears the registers to their defaults
// (mac_length 20) and returns the block to header collection; after a fatal
// header error the block accepts and drops all bytes until reset.
`include "tls_record_deframer_defines.svh"

module tls_record_deframer import tlsd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  stream_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        is_payload_o,
  output logic [2:0]  status_o,
  output logic [7:0]  content_type_o,
  output logic [15:0] version_o,
  output logic [15:0] record_length_o,
  output logic [63:0] record_sequence_o,
  output logic [7:0]  payload_byte_o,
  output logic        last_o
);

  logic                 dtls_mode_q;
  logic [6:0]           mac_length_q;
  logic [15:0]          read_epoch_q;

  logic                 byte_valid_q, byte_valid_d;
  logic [7:0]           byte_q;

  phase_e               phase_q, phase_d;
  logic [HDR_CNT_W-1:0] hdr_cnt_q, hdr_cnt_d;
  hdr_bytes_t           hdr_q;
  logic [15:0]          rem_q, rem_d;
  logic [63:0]          read_seq_q, read_seq_d;

  logic [HDR_CNT_W-1:0] head_cnt;
  logic [HDR_CNT_W-1:0] cnt_inc;
  logic                 hdr_done;
  hdr_bytes_t           hdr_view;
  hdr_info_t            info;
  logic [15:0]          rem_dec;

  logic                 produce;
  logic                 advance;
  logic                 accept_in;
  logic                 out_free;
  result_t              res_d;
  result_t              res_q;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dtls_mode_q  <= 1'b0;
      mac_length_q <= MAC_LEN_RESET;
      read_epoch_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_DTLS_MODE:  dtls_mode_q  <= cfg_data_i[0];
        CFG_MAC_LENGTH: mac_length_q <= cfg_data_i[6:0];
        CFG_READ_EPOCH: read_epoch_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register.
  assign in_stall_o   = byte_valid_q && !advance;
  assign accept_in    = in_valid_i && !in_stall_o;
  assign byte_valid_d = accept_in || (byte_valid_q && !advance);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_valid_q <= 1'b0;
    end else begin
      byte_valid_q <= byte_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      byte_q <= stream_byte_i;
    end
  end

  // Header view with the current byte laid over the stored entries.
  assign head_cnt = dtls_mode_q ? DTLS_HEAD_CNT : TLS_HEAD_CNT;
  assign cnt_inc  = hdr_cnt_q + HDR_CNT_W'(1);
  assign hdr_done = (cnt_inc >= head_cnt);
  assign rem_dec  = rem_q - 16'd1;

  always_comb begin
    for (int i = 0; i < HDR_DEPTH; i++) begin
      hdr_view[i] = (hdr_cnt_q == HDR_CNT_W'(i)) ? byte_q : hdr_q[i];
    end
  end

  tlsd_hdr_check u_hdr_check (
    .hdr_i        (hdr_view),
    .dtls_mode_i  (dtls_mode_q),
    .mac_length_i (mac_length_q),
    .read_epoch_i (read_epoch_q),
    .read_seq_i   (read_seq_q),
    .info_o       (info)
  );

  // Record state machine: next state and result word.
  always_comb begin
    phase_d    = phase_q;
    hdr_cnt_d  = hdr_cnt_q;
    rem_d      = rem_q;
    read_seq_d = read_seq_q;
    produce    = 1'b0;
    res_d      = '0;
    unique case (phase_q)
      PH_HEADER: begin
        hdr_cnt_d = cnt_inc;
        if (hdr_done) begin
          hdr_cnt_d                 = '0;
          produce                   = 1'b1;
          res_d.status              = info.status;
          res_d.content_type        = info.content_type;
          res_d.version             = info.version;
          res_d.record_length       = info.length;
          res_d.record_sequence     = info.seq;
          res_d.last                = (info.status != ST_OK) || (info.length == 16'd0);
          read_seq_d                = info.seq;
          if (info.fatal) begin
            phase_d = PH_HALT;
          end else begin
            rem_d = info.length;
            if (!info.skip) begin
              read_seq_d = info.seq + 64'd1;
            end
            if (info.length == 16'd0) begin
              phase_d = PH_HEADER;
            end else begin
              phase_d = info.skip ? PH_SKIP : PH_PAYLOAD;
            end
          end
        end
      end
      PH_PAYLOAD: begin
        produce            = 1'b1;
        rem_d              = rem_dec;
        res_d.is_payload   = 1'b1;
        res_d.payload_byte = byte_q;
        res_d.last         = (rem_dec == 16'd0);
        if (rem_dec == 16'd0) begin
          phase_d = PH_HEADER;
        end
      end
      PH_SKIP: begin
        rem_d = rem_dec;
        if (rem_dec == 16'd0) begin
          phase_d = PH_HEADER;
        end
      end
      PH_HALT: begin
      end
      default: begin
      end
    endcase
  end

  // A byte moves on when it needs no result slot or the slot is free.
  assign advance = byte_valid_q && (!produce || out_free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HEADER;
      hdr_cnt_q  <= '0;
      rem_q      <= '0;
      read_seq_q <= '0;
    end else if (advance) begin
      phase_q    <= phase_d;
      hdr_cnt_q  <= hdr_cnt_d;
      rem_q      <= rem_d;
      read_seq_q <= read_seq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < HDR_DEPTH; i++) begin
      if (advance && (phase_q == PH_HEADER) && (hdr_cnt_q == HDR_CNT_W'(i))) begin
        hdr_q[i] <= byte_q;
      end
    end
  end

  tlsd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && produce),
    .data_i      (res_d),
    .out_stall_i (out_stall_i),
    .free_o      (out_free),
    .valid_o     (out_valid_o),
    .data_o      (res_q)
  );

  assign is_payload_o      = res_q.is_payload;
  assign status_o          = res_q.status;
  assign content_type_o    = res_q.content_type;
  assign version_o         = res_q.version;
  assign record_length_o   = res_q.record_length;
  assign record_sequence_o = res_q.record_sequence;
  assign payload_byte_o    = res_q.payload_byte;
  assign last_o            = res_q.last;

  `TLSD_ASSERT_IMP(a_hdr_cnt_range, 1'b1, hdr_cnt_q < DTLS_HEAD_CNT,
    "header count ran past the longest header")
  `TLSD_ASSERT_NXT(a_halt_sticky, phase_q == PH_HALT, phase_q == PH_HALT,
    "block left the halted phase without reset")
  `TLSD_ASSERT_IMP(a_payload_left, phase_q == PH_PAYLOAD || phase_q == PH_SKIP,
    rem_q != 16'd0, "payload phase entered with no bytes remaining")
  `TLSD_ASSERT_IMP(a_error_last, out_valid_o && !is_payload_o && status_o != ST_OK,
    last_o, "error header result without last marker")

endmodule

FILE: design/tlsd_hdr_check.sv
// Header decode and checking for the record deframer.
// Depends on tlsd_pkg; purely combinational.
module tlsd_hdr_check import tlsd_pkg::*; (
  input  hdr_bytes_t  hdr_i,
  input  logic        dtls_mode_i,
  input  logic [6:0]  mac_length_i,
  input  logic [15:0] read_epoch_i,
  input  logic [63:0] read_seq_i,
  output hdr_info_t   info_o
);

  logic [7:0]  ctype;
  logic [15:0] length;
  logic [63:0] hdr_seq;
  logic        bad_type;
  logic        epoch_ok;
  logic        load_seq;

  assign ctype    = hdr_i[0];
  assign length   = dtls_mode_i ? {hdr_i[11], hdr_i[12]} : {hdr_i[3], hdr_i[4]};
  assign hdr_seq  = {hdr_i[3], hdr_i[4], hdr_i[5], hdr_i[6],
                     hdr_i[7], hdr_i[8], hdr_i[9], hdr_i[10]};
  assign bad_type = (ctype < TYPE_LOW) || (ctype > TYPE_HIGH);
  assign epoch_ok = ({hdr_i[3], hdr_i[4]} == read_epoch_i);
  assign load_seq = !bad_type && dtls_mode_i && epoch_ok;

  always_comb begin
    info_o              = '0;
    info_o.content_type = ctype;
    info_o.version      = {hdr_i[1], hdr_i[2]};
    info_o.length       = length;
    info_o.seq          = load_seq ? hdr_seq : read_seq_i;
    info_o.skip         = dtls_mode_i && !epoch_ok;
    // The order of these checks decides which status a faulty header reports.
    priority if (bad_type) begin
      info_o.status = ST_BAD_TYPE;
      info_o.fatal  = 1'b1;
    end else if (length > MAX_RECORD_LEN) begin
      info_o.status = ST_OVERFLOW;
      info_o.fatal  = 1'b1;
    end else if (info_o.skip) begin
      info_o.status = ST_STALE;
    end else if (length < {9'd0, mac_length_i}) begin
      info_o.status = ST_SHORT;
      info_o.fatal  = 1'b1;
    end else begin
      info_o.status = ST_OK;
    end
  end

endmodule

FILE: design/tlsd_out_reg.sv
// Result register of the record deframer, holding one word for the receiver.
// Depends on tlsd_pkg for the result type.
module tlsd_out_reg import tlsd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t data_i,
  input  logic    out_stall_i,
  output logic    free_o,
  output logic    valid_o,
  output result_t data_o
);

  logic    valid_q, valid_d;
  result_t data_q;

  // The register can take a new word when empty or when its word leaves now.
  assign free_o  = !valid_q || !out_stall_i;
  assign valid_d = load_i || (valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for tls_record_deframer: directed records, then random
// TLS and DTLS record streams checked against a behavioural predictor.
// Depends on tlsd_pkg and the deframer RTL only.
module testbench import tlsd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS  = 1050;
  localparam int PHASE_ITEMS   = 150;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 800000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  stream_byte_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        is_payload_o;
  logic [2:0]  status_o;
  logic [7:0]  content_type_o;
  logic [15:0] version_o;
  logic [15:0] record_length_o;
  logic [63:0] record_sequence_o;
  logic [7:0]  payload_byte_o;
  logic        last_o;

  tls_record_deframer DUT (.*);

  always #5 clk_i = ~clk_i;

  typedef struct {
    bit          is_cfg;
    cfg_idx_e    idx;
    logic [15:0] data;
    bit          typed;
    result_t     want;
  } stim_row_t;

  // Testbench copy of the configuration and of the record state.
  logic        cfg_dtls = 1'b0;
  logic [6:0]  cfg_mac = MAC_LEN_RESET;
  logic [15:0] cfg_epoch = '0;
  phase_e      ph = PH_HEADER;
  logic [3:0]  hcount = '0;
  logic [7:0]  hbytes [HDR_DEPTH];
  logic [15:0] remain = '0;
  logic [63:0] rseq = '0;

  result_t     pending_words [$];
  stim_row_t   dir_tbl [$];
  int          errors = 0;
  int          cycles = 0;
  int          bytes_sent = 0;
  bit          sender_calm = 1'b0;
  bit          recv_calm = 1'b0;
  bit          hold_for_drain = 1'b0;
  bit          out_hold = 1'b0;
  int          hold_cnt = 0;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic stim_row_t cfg_row(input cfg_idx_e idx, input logic [15:0] val);
    stim_row_t row;
    row = '{is_cfg: 1'b1, idx: idx, data: val, typed: 1'b0, want: '0};
    return row;
  endfunction

  function automatic stim_row_t byte_row(input logic [7:0] b);
    stim_row_t row;
    row = '{is_cfg: 1'b0, idx: CFG_DTLS_MODE, data: {8'h00, b}, typed: 1'b0, want: '0};
    return row;
  endfunction

  function automatic stim_row_t hdr_row(input logic [7:0] b, input status_e st,
                                        input logic [7:0] typ, input logic [15:0] ver,
                                        input logic [15:0] len, input logic [63:0] seq,
                                        input logic last);
    stim_row_t row;
    row = byte_row(b);
    row.typed = 1'b1;
    row.want.status = st;
    row.want.content_type = typ;
    row.want.version = ver;
    row.want.record_length = len;
    row.want.record_sequence = seq;
    row.want.last = last;
    return row;
  endfunction

  function automatic stim_row_t pay_row(input logic [7:0] b, input logic last);
    stim_row_t row;
    row = byte_row(b);
    row.typed = 1'b1;
    row.want.is_payload = 1'b1;
    row.want.payload_byte = b;
    row.want.last = last;
    return row;
  endfunction

  // Advances the record state by one stream byte; returns 1 when a word is due.
  function automatic bit deframe_byte(input logic [7:0] b, output result_t r);
    logic [7:0]  typ;
    logic [15:0] ver;
    logic [15:0] len;
    logic [63:0] seq;
    bit          skip;
    bit          got;
    got = 1'b0;
    skip = 1'b0;
    r = '0;
    case (ph)
      PH_HEADER: begin
        if (hcount < 4'(HDR_DEPTH)) hbytes[hcount] = b;
        hcount = hcount + 4'd1;
        if (hcount >= (cfg_dtls ? DTLS_HEAD_CNT : TLS_HEAD_CNT)) begin
          hcount = '0;
          got = 1'b1;
          typ = hbytes[0];
          ver = {hbytes[1], hbytes[2]};
          len = cfg_dtls ? {hbytes[11], hbytes[12]} : {hbytes[3], hbytes[4]};
          r.content_type = typ;
          r.version = ver;
          r.record_length = len;
          r.last = 1'b1;
          if (typ < TYPE_LOW || typ > TYPE_HIGH) begin
            ph = PH_HALT;
            r.status = ST_BAD_TYPE;
            r.record_sequence = rseq;
          end else begin
            if (cfg_dtls) begin
              seq = {hbytes[3], hbytes[4], hbytes[5], hbytes[6],
                     hbytes[7], hbytes[8], hbytes[9], hbytes[10]};
              if (seq[63:48] != cfg_epoch) skip = 1'b1;
              else rseq = seq;
            end
            r.record_sequence = rseq;
            if (len > MAX_RECORD_LEN) begin
              ph = PH_HALT;
              r.status = ST_OVERFLOW;
            end else if (skip) begin
              remain = len;
              ph = (len != 0) ? PH_SKIP : PH_HEADER;
              r.status = ST_STALE;
            end else if (len < 16'(cfg_mac)) begin
              ph = PH_HALT;
              r.status = ST_SHORT;
            end else begin
              r.status = ST_OK;
              r.last = (len == 0);
              rseq = rseq + 64'd1;
              remain = len;
              ph = (len != 0) ? PH_PAYLOAD : PH_HEADER;
            end
          end
        end
      end
      PH_PAYLOAD: begin
        remain = remain - 16'd1;
        if (remain == 0) ph = PH_HEADER;
        r.is_payload = 1'b1;
        r.payload_byte = b;
        r.last = (remain == 0);
        got = 1'b1;
      end
      PH_SKIP: begin
        remain = remain - 16'd1;
        if (remain == 0) ph = PH_HEADER;
      end
      default: ;
    endcase
    return got;
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: %s mismatch, got %0h, want %0h", $realtime, field, got, want);
    errors++;
  endtask

  task automatic send_byte(input logic [7:0] b, input bit typed, input result_t want);
    int      gap;
    result_t r;
    gap = sender_calm ? 0 : gap_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    stream_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    if (deframe_byte(b, r)) pending_words.push_back(typed ? want : r);
    bytes_sent++;
  endtask

  task automatic send_record(input logic [7:0] typ, input logic [15:0] ver,
                             input logic [15:0] ep, input logic [47:0] sq,
                             input logic [15:0] len, input int body);
    logic [63:0] dseq;
    logic [7:0]  hdr [HDR_DEPTH];
    int          n;
    dseq = {ep, sq};
    hdr[0] = typ;
    hdr[1] = ver[15:8];
    hdr[2] = ver[7:0];
    for (int i = 0; i < 8; i++) hdr[3 + i] = dseq[63 - 8*i -: 8];
    n = cfg_dtls ? 13 : 5;
    hdr[n - 2] = len[15:8];
    hdr[n - 1] = len[7:0];
    for (int i = 0; i < n; i++) send_byte(hdr[i], 1'b0, '0);
    // Hold the stream back until the header word and everything before it is out.
    if (hold_for_drain) begin
      hold_for_drain = 1'b0;
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while (pending_words.size() != 0);
    end
    for (int i = 0; i < body; i++) send_byte(8'($urandom), 1'b0, '0);
  endtask

  task automatic drain_settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_words.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_DTLS_MODE:  cfg_dtls = val[0];
      CFG_MAC_LENGTH: cfg_mac = val[6:0];
      CFG_READ_EPOCH: cfg_epoch = val;
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Receiver: runs of acceptance and stall of random length.
  always @(posedge clk_i) begin
    if (hold_cnt == 0) begin
      out_hold = !recv_calm && ($urandom_range(0, 2) == 0);
      hold_cnt = out_hold ? 1 + gap_len() : $urandom_range(1, 24);
    end
    hold_cnt--;
    out_stall_i <= out_hold;
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_words.size() == 0) begin
        report_mismatch("unexpected word", 64'(is_payload_o), 64'd0);
      end else begin
        want = pending_words.pop_front();
        if (is_payload_o !== want.is_payload)
          report_mismatch("is_payload", 64'(is_payload_o), 64'(want.is_payload));
        if (status_o !== want.status)
          report_mismatch("status", 64'(status_o), 64'(want.status));
        if (content_type_o !== want.content_type)
          report_mismatch("content_type", 64'(content_type_o), 64'(want.content_type));
        if (version_o !== want.version)
          report_mismatch("version", 64'(version_o), 64'(want.version));
        if (record_length_o !== want.record_length)
          report_mismatch("record_length", 64'(record_length_o), 64'(want.record_length));
        if (record_sequence_o !== want.record_sequence)
          report_mismatch("record_sequence", record_sequence_o, want.record_sequence);
        if (payload_byte_o !== want.payload_byte)
          report_mismatch("payload_byte", 64'(payload_byte_o), 64'(want.payload_byte));
        if (last_o !== want.last)
          report_mismatch("last", 64'(last_o), 64'(want.last));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int          phase_no;
    int          phase_start;
    int          variant;
    bit          stale;
    logic [6:0]  mac;
    logic [7:0]  typ;
    logic [15:0] ep;
    logic [15:0] len;
    logic [47:0] sq;

    // Empty records carry last on the header word; the two payload bytes sit at
    // the byte extremes. The all-ones DTLS sequence wraps the counter to zero,
    // which the following stale record then reports.
    dir_tbl.push_back(cfg_row(CFG_MAC_LENGTH, 16'd0));
    dir_tbl.push_back(byte_row(8'h14)); dir_tbl.push_back(byte_row(8'h03));
    dir_tbl.push_back(byte_row(8'h01)); dir_tbl.push_back(byte_row(8'h00));
    dir_tbl.push_back(hdr_row(8'h00, ST_OK, 8'h14, 16'h0301, 16'd0, 64'd0, 1'b1));
    dir_tbl.push_back(byte_row(8'h17)); dir_tbl.push_back(byte_row(8'hFF));
    dir_tbl.push_back(byte_row(8'hFF)); dir_tbl.push_back(byte_row(8'h00));
    dir_tbl.push_back(hdr_row(8'h02, ST_OK, 8'h17, 16'hFFFF, 16'd2, 64'd1, 1'b0));
    dir_tbl.push_back(pay_row(8'hFF, 1'b0));
    dir_tbl.push_back(pay_row(8'h00, 1'b1));
    dir_tbl.push_back(cfg_row(CFG_DTLS_MODE, 16'd1));
    dir_tbl.push_back(cfg_row(CFG_READ_EPOCH, 16'hFFFF));
    dir_tbl.push_back(byte_row(8'h16)); dir_tbl.push_back(byte_row(8'hFE));
    dir_tbl.push_back(byte_row(8'hFD));
    for (int i = 0; i < 8; i++) dir_tbl.push_back(byte_row(8'hFF));
    dir_tbl.push_back(byte_row(8'h00));
    dir_tbl.push_back(hdr_row(8'h00, ST_OK, 8'h16, 16'hFEFD, 16'd0, '1, 1'b1));
    dir_tbl.push_back(byte_row(8'h15)); dir_tbl.push_back(byte_row(8'hFE));
    dir_tbl.push_back(byte_row(8'hFF));
    for (int i = 0; i < 7; i++) dir_tbl.push_back(byte_row(8'h00));
    dir_tbl.push_back(byte_row(8'h05)); dir_tbl.push_back(byte_row(8'h00));
    dir_tbl.push_back(hdr_row(8'h01, ST_STALE, 8'h15, 16'hFEFF, 16'd1, 64'd0, 1'b1));
    dir_tbl.push_back(byte_row(8'h5A));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].is_cfg) begin
        drain_settle();
        write_reg(dir_tbl[i].idx, dir_tbl[i].data);
      end else begin
        send_byte(dir_tbl[i].data[7:0], dir_tbl[i].typed, dir_tbl[i].want);
      end
    end

    bytes_sent = 0;
    phase_no = 0;
    hold_for_drain = 1'b1;
    while (bytes_sent < RANDOM_ITEMS) begin
      drain_settle();
      case (phase_no)
        0: mac = 7'd0;
        1: mac = 7'd64;
        2: mac = 7'd127;
        3: mac = 7'd1;
        default: mac = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(65, 127))
                                                    : 7'($urandom_range(0, 64));
      endcase
      case (phase_no)
        0: ep = 16'hFFFF;
        1: ep = 16'h0000;
        default: ep = 16'($urandom);
      endcase
      write_reg(CFG_DTLS_MODE, {15'($urandom),
                                phase_no < 4 ? phase_no[0] : 1'($urandom)});
      write_reg(CFG_MAC_LENGTH, {9'($urandom), mac});
      write_reg(CFG_READ_EPOCH, ep);
      sender_calm = ($urandom_range(0, 4) == 0);
      recv_calm = ($urandom_range(0, 4) == 0);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_ITEMS && bytes_sent < RANDOM_ITEMS) begin
        stale = cfg_dtls && ($urandom_range(0, 3) == 0);
        sq = ($urandom_range(0, 9) == 0) ? 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 2))
                                         : 48'({$urandom, $urandom});
        if (stale) begin
          // Another epoch: any short length is fine, the record is dropped.
          ep = cfg_epoch ^ 16'($urandom_range(1, 65535));
          len = 16'($urandom_range(0, 40));
        end else begin
          ep = cfg_epoch;
          case ($urandom_range(0, 9))
            0, 1:    len = 16'(cfg_mac);
            8, 9:    len = 16'(cfg_mac) + 16'($urandom_range(25, 150));
            default: len = 16'(cfg_mac) + 16'($urandom_range(0, 24));
          endcase
        end
        if ($urandom_range(0, 40) == 0) hold_for_drain = 1'b1;
        send_record(8'($urandom_range(TYPE_LOW, TYPE_HIGH)), 16'($urandom), ep, sq, len,
                    int'(len));
      end
      phase_no++;
    end

    // Only one header error can be shown per run, as the block then halts.
    drain_settle();
    sender_calm = 1'b0;
    recv_calm = 1'b0;
    variant = $urandom_range(0, 3);
    write_reg(CFG_DTLS_MODE, 16'($urandom_range(0, 1)));
    write_reg(CFG_MAC_LENGTH,
              16'(variant == 2 ? $urandom_range(1, 127) : $urandom_range(0, 64)));
    write_reg(CFG_READ_EPOCH, 16'($urandom));
    ep = (variant != 2 && variant != 3 && $urandom_range(0, 1) == 1) ? 16'($urandom)
                                                                     : cfg_epoch;
    sq = 48'({$urandom, $urandom});
    typ = 8'($urandom_range(TYPE_LOW, TYPE_HIGH));
    case (variant)
      0: begin
        case ($urandom_range(0, 4))
          0:       typ = TYPE_LOW - 8'd1;
          1:       typ = TYPE_HIGH + 8'd1;
          2:       typ = 8'h00;
          3:       typ = 8'hFF;
          default: typ = 8'($urandom_range(24, 255));
        endcase
        send_record(typ, 16'($urandom), ep, sq, 16'($urandom), 0);
      end
      1: begin
        case ($urandom_range(0, 2))
          0:       len = MAX_RECORD_LEN + 16'd1;
          1:       len = 16'hFFFF;
          default: len = 16'($urandom_range(18433, 65535));
        endcase
        send_record(typ, 16'($urandom), ep, sq, len, 0);
      end
      2: send_record(typ, 16'($urandom), ep, sq,
                     16'($urandom_range(0, int'(cfg_mac) - 1)), 0);
      default: send_record(typ, 16'($urandom), ep, sq, MAX_RECORD_LEN,
                           $urandom_range(0, 20));
    endcase
    // After a header error every further word is dropped.
    if (variant != 3) repeat (12) send_byte(8'($urandom), 1'b0, '0);

    drain_settle();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
